### hdl/bfd_pkg.sv
// Package for the box filter image downscaler.
// Holds register indexes, reset values, field widths and the controller state type.
// No dependencies.
`default_nettype none
package bfd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_RATIO_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 11;
    localparam int STEP_W     = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1;
    localparam logic [STEP_W-1:0] STEP_RESET = 23'h010000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_MUL_Y,
        ST_LD_Y,
        ST_COL,
        ST_MUL_X,
        ST_LD_X,
        ST_CHECK,
        ST_READ,
        ST_ADD,
        ST_DIV,
        ST_OUT,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic row_start;
        logic mul_row;
        logic mul_col;
        logic ld_y;
        logic ld_x;
        logic col_step;
        logic check;
        logic mem_read;
        logic add;
        logic out_load;
        logic advance;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_adv;
        logic col_adv;
        logic in_box;
        logic is_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### hdl/bfd_div.sv
// Three-lane restoring divider, one quotient bit per cycle in each lane.
// Depends on bfd_pkg for the pixel width.
`default_nettype none
module bfd_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [2:0][NUM_W-1:0]              num,
    input  wire logic [DEN_W-1:0]                   den,
    output logic                                    done,
    output logic [2:0][bfd_pkg::PIX_W-1:0]          quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [2:0][NUM_W-1:0] q_reg, q_next;
    logic [2:0][DEN_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb
    begin
        logic [DEN_W:0] trial;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial = {r_reg[c], q_reg[c][NUM_W-1]};
                if (trial >= {1'b0, den})
                begin
                    r_next[c] = DEN_W'(trial - {1'b0, den});
                    q_next[c] = {q_reg[c][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_next[c] = trial[DEN_W-1:0];
                    q_next[c] = {q_reg[c][NUM_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            quot[c] = q_reg[c][bfd_pkg::PIX_W-1:0];
    end

endmodule
`default_nettype wire

### hdl/bfd_datapath.sv
// Datapath of the downscaler: configuration, counters, box origins, column sum memory,
// shared origin multiplier and output register. Depends on bfd_pkg and bfd_div.
`default_nettype none
module bfd_datapath #(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RATIO = bfd_pkg::MAX_RATIO_DEF,
    parameter int FRAC_BITS = bfd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [bfd_pkg::PIX_W-1:0]         red,
    input  wire logic [bfd_pkg::PIX_W-1:0]         green,
    input  wire logic [bfd_pkg::PIX_W-1:0]         blue,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [bfd_pkg::PIX_W-1:0]              out_red,
    output logic [bfd_pkg::PIX_W-1:0]              out_green,
    output logic [bfd_pkg::PIX_W-1:0]              out_blue,
    output logic                                   last_in_frame,
    input  wire bfd_pkg::cmd_t                     cmd,
    output bfd_pkg::status_t                       status
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int NW   = $clog2(MAX_WIDTH + 1);
    localparam int SW   = $clog2(MAX_RATIO) + FRAC_BITS + 1;
    localparam int BW   = $clog2(MAX_RATIO + 1);
    localparam int AW   = $clog2(MAX_RATIO * MAX_RATIO + 1);
    localparam int SUMW = bfd_pkg::PIX_W + AW;
    localparam int PW   = NW + SW;
    localparam int OW   = PW - FRAC_BITS;
    localparam int EW   = OW + 1;
    localparam int PX   = bfd_pkg::PIX_W;

    // Configuration registers.
    logic [bfd_pkg::SIZE_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [bfd_pkg::STEP_W-1:0] x_step_reg, y_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= bfd_pkg::SIZE_RESET;
            src_h_reg  <= bfd_pkg::SIZE_RESET;
            dst_w_reg  <= bfd_pkg::SIZE_RESET;
            dst_h_reg  <= bfd_pkg::SIZE_RESET;
            x_step_reg <= bfd_pkg::STEP_RESET;
            y_step_reg <= bfd_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfd_pkg::REG_SRC_WIDTH:  src_w_reg  <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_SRC_HEIGHT: src_h_reg  <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_DST_WIDTH:  dst_w_reg  <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_DST_HEIGHT: dst_h_reg  <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_X_STEP:     x_step_reg <= cfg_data;
                bfd_pkg::REG_Y_STEP:     y_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped working values.
    logic [NW-1:0] sw, sh, dw, dh;
    logic [SW-1:0] xs, ys;
    logic [BW-1:0] bw, bh;

    function automatic logic [NW-1:0] clamp_size(input logic [bfd_pkg::SIZE_W-1:0] v,
                                                 input logic lo_one);
        logic [31:0] w;
        w = 32'(v);
        if (lo_one && w == 32'd0)
            return NW'(1);
        if (w > 32'(MAX_WIDTH))
            return NW'(MAX_WIDTH);
        return NW'(w);
    endfunction

    function automatic logic [SW-1:0] clamp_step(input logic [bfd_pkg::STEP_W-1:0] v);
        logic [63:0] w, lo, hi;
        w  = 64'(v);
        lo = 64'(1) << FRAC_BITS;
        hi = 64'(MAX_RATIO) << FRAC_BITS;
        if (w < lo)
            return SW'(lo);
        if (w > hi)
            return SW'(hi);
        return SW'(w);
    endfunction

    assign sw = clamp_size(src_w_reg, 1'b1);
    assign sh = clamp_size(src_h_reg, 1'b1);
    assign dw = clamp_size(dst_w_reg, 1'b0);
    assign dh = clamp_size(dst_h_reg, 1'b0);
    assign xs = clamp_step(x_step_reg);
    assign ys = clamp_step(y_step_reg);
    assign bw = BW'(xs >> FRAC_BITS);
    assign bh = BW'(ys >> FRAC_BITS);

    // Position state.
    logic [CW-1:0] src_col_reg, src_row_reg;
    logic [NW-1:0] out_col_reg, out_row_reg;
    logic [OW-1:0] box_x_reg, box_y_reg;
    logic [PW-1:0] prod_reg;
    logic [PX-1:0] px_reg [3];

    logic [EW-1:0] row_e, col_e, bx_e, by_e, bx_end, by_end;
    assign row_e  = EW'(src_row_reg);
    assign col_e  = EW'(src_col_reg);
    assign bx_e   = EW'(box_x_reg);
    assign by_e   = EW'(box_y_reg);
    assign bx_end = bx_e + EW'(bw);
    assign by_end = by_e + EW'(bh);

    logic col_zero, row_adv, col_adv, in_box, first, last;
    assign col_zero = (src_col_reg == '0);
    assign row_adv  = col_zero && (out_row_reg < dh) && (row_e >= by_end);
    assign col_adv  = (out_col_reg < dw) && (col_e >= bx_end);
    assign in_box   = (out_row_reg < dh) && (out_col_reg < dw) &&
                      (row_e >= by_e) && (row_e < by_end) &&
                      (col_e >= bx_e) && (col_e < bx_end);
    assign first    = (row_e == by_e) && (col_e == bx_e);
    assign last     = (row_e + EW'(1) == by_end) && (col_e + EW'(1) == bx_end);

    logic [NW-1:0] mul_a;
    assign mul_a = cmd.mul_row ? out_row_reg : out_col_reg;

    logic [CW:0] col_inc, row_inc;
    assign col_inc = {1'b0, src_col_reg} + 1'b1;
    assign row_inc = {1'b0, src_row_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            box_x_reg   <= '0;
            box_y_reg   <= '0;
        end
        else
        begin
            if (cmd.row_start)
            begin
                if (col_zero)
                begin
                    out_col_reg <= '0;
                    box_x_reg   <= '0;
                end
                if (row_adv)
                    out_row_reg <= out_row_reg + 1'b1;
            end
            if (cmd.ld_y)
                box_y_reg <= prod_reg[PW-1:FRAC_BITS];
            if (cmd.col_step && col_adv)
                out_col_reg <= out_col_reg + 1'b1;
            if (cmd.ld_x)
                box_x_reg <= prod_reg[PW-1:FRAC_BITS];
            if (cmd.advance)
            begin
                if (NW'(col_inc) >= sw)
                begin
                    src_col_reg <= '0;
                    if (NW'(row_inc) >= sh)
                    begin
                        src_row_reg <= '0;
                        out_row_reg <= '0;
                        box_y_reg   <= '0;
                    end
                    else
                        src_row_reg <= row_inc[CW-1:0];
                end
                else
                    src_col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Working registers for one pixel.
    logic            first_reg, last_reg, frame_end_reg;
    logic [AW-1:0]   area_reg;
    logic [3*SUMW-1:0] rd_reg;

    function automatic logic [SW-1:0] mul_row_step(input logic sel_row);
        return sel_row ? ys : xs;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg[0] <= red;
            px_reg[1] <= green;
            px_reg[2] <= blue;
        end
        if (cmd.mul_row || cmd.mul_col)
            prod_reg <= PW'(mul_a * (mul_row_step(cmd.mul_row)));
        if (cmd.check)
        begin
            first_reg     <= first;
            last_reg      <= last;
            frame_end_reg <= (out_col_reg == dw - 1'b1) && (out_row_reg == dh - 1'b1);
            area_reg      <= AW'(bw * bh);
        end
    end

    // Column sum memory, three channel sums per output column.
    logic [3*SUMW-1:0] col_mem [MAX_WIDTH];
    logic [3*SUMW-1:0] sum_word;
    logic [2:0][SUMW-1:0] sum_ch;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (first_reg)
                sum_ch[c] = SUMW'(px_reg[c]);
            else
                sum_ch[c] = rd_reg[c*SUMW +: SUMW] + SUMW'(px_reg[c]);
            sum_word[c*SUMW +: SUMW] = sum_ch[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
            rd_reg <= col_mem[out_col_reg[CW-1:0]];
        if (cmd.add)
            col_mem[out_col_reg[CW-1:0]] <= sum_word;
    end

    logic                 div_done;
    logic [2:0][PX-1:0]   quot;

    bfd_div #(
        .NUM_W (SUMW),
        .DEN_W (AW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.add && last_reg),
        .num   (sum_ch),
        .den   (area_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Output register.
    logic out_valid_reg;
    logic [PX-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_r_reg    <= quot[0];
            out_g_reg    <= quot[1];
            out_b_reg    <= quot[2];
            out_last_reg <= frame_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_r_reg;
    assign out_green     = out_g_reg;
    assign out_blue      = out_b_reg;
    assign last_in_frame = out_last_reg;

    assign status.row_adv  = row_adv;
    assign status.col_adv  = col_adv;
    assign status.in_box   = in_box;
    assign status.is_last  = last_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule
`default_nettype wire

### hdl/bfd_ctrl.sv
// Controller state machine that sequences one source pixel through the datapath.
// Depends on bfd_pkg for the state, command and status types.
`default_nettype none
module bfd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bfd_pkg::status_t  status,
    output bfd_pkg::cmd_t          cmd
);

    bfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bfd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != bfd_pkg::ST_IDLE);
        unique case (state_reg)
            bfd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bfd_pkg::ST_ROW;
                end
            end
            bfd_pkg::ST_ROW:
            begin
                cmd.row_start = 1'b1;
                state_next = status.row_adv ? bfd_pkg::ST_MUL_Y : bfd_pkg::ST_COL;
            end
            bfd_pkg::ST_MUL_Y:
            begin
                cmd.mul_row = 1'b1;
                state_next  = bfd_pkg::ST_LD_Y;
            end
            bfd_pkg::ST_LD_Y:
            begin
                cmd.ld_y   = 1'b1;
                state_next = bfd_pkg::ST_COL;
            end
            bfd_pkg::ST_COL:
            begin
                cmd.col_step = 1'b1;
                state_next = status.col_adv ? bfd_pkg::ST_MUL_X : bfd_pkg::ST_CHECK;
            end
            bfd_pkg::ST_MUL_X:
            begin
                cmd.mul_col = 1'b1;
                state_next  = bfd_pkg::ST_LD_X;
            end
            bfd_pkg::ST_LD_X:
            begin
                cmd.ld_x   = 1'b1;
                state_next = bfd_pkg::ST_CHECK;
            end
            bfd_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.in_box ? bfd_pkg::ST_READ : bfd_pkg::ST_FIN;
            end
            bfd_pkg::ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = bfd_pkg::ST_ADD;
            end
            bfd_pkg::ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = status.is_last ? bfd_pkg::ST_DIV : bfd_pkg::ST_FIN;
            end
            bfd_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = bfd_pkg::ST_OUT;
            end
            bfd_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bfd_pkg::ST_FIN;
                end
            end
            bfd_pkg::ST_FIN:
            begin
                cmd.advance = 1'b1;
                state_next  = bfd_pkg::ST_IDLE;
            end
            default:
                state_next = bfd_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### hdl/box_filter_image_downscale.sv
// Box filter image downscaler. Source RGB pixels enter one word at a time in raster
// order; each output pixel is the truncated mean of a floor(x_step) by floor(y_step)
// block of source pixels whose corner sits at the floored positions x*x_step and
// y*y_step (unsigned fixed point with FRAC_BITS fraction bits). A result word leaves
// when the bottom-right pixel of its box arrives, with last_in_frame set on the final
// output pixel. The block works on one source pixel at a time. A pixel in no box passes
// the row, column, check and finish states before the next is taken; each moving box
// origin adds a multiply in the one shared multiplier and a register load. A pixel
// inside a box adds a column sum read and write; one closing a box waits for the
// divider, as the three channel quotients come out of a restoring divider one bit per
// cycle. A finished word waits in the output register while the next pixel is taken
// in; only a second finished word stalls behind it. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them only while
// the block is idle; the block does not enforce it. The column sum memory needs no
// clearing after reset because every box writes its entry before adding to it.
`default_nettype none
module box_filter_image_downscale #(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RATIO = bfd_pkg::MAX_RATIO_DEF,
    parameter int FRAC_BITS = bfd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bfd_pkg::PIX_W-1:0]         red,
    input  wire logic [bfd_pkg::PIX_W-1:0]         green,
    input  wire logic [bfd_pkg::PIX_W-1:0]         blue,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bfd_pkg::PIX_W-1:0]              out_red,
    output logic [bfd_pkg::PIX_W-1:0]              out_green,
    output logic [bfd_pkg::PIX_W-1:0]              out_blue,
    output logic                                   last_in_frame
);

    // The controller and the datapath talk only through these two groups.
    bfd_pkg::cmd_t    cmd;
    bfd_pkg::status_t status;

    bfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bfd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RATIO (MAX_RATIO),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .last_in_frame (last_in_frame),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
`default_nettype wire

### hdl/bfd_checker.sv
// Port-level checks for the downscaler, attached to the top level by a bind.
// Depends on bfd_pkg for port widths.
`default_nettype none
module bfd_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [bfd_pkg::PIX_W-1:0]  out_red,
    input wire logic [bfd_pkg::PIX_W-1:0]  out_green,
    input wire logic [bfd_pkg::PIX_W-1:0]  out_blue,
    input wire logic                       last_in_frame
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
                                   $stable(out_blue) && $stable(last_in_frame))
        else $error("result payload changed while stalled");

    // One pixel is in work at a time: after a pixel is taken the input stalls.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel taken while one is in work");

    // A new result word only appears while a pixel is being worked on.
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a pixel in work");

endmodule

bind box_filter_image_downscale bfd_checker u_bfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .last_in_frame (last_in_frame)
);
`default_nettype wire

### verif/box_filter_image_downscale_test.sv
// Self-checking testbench for the box filter image downscaler.
// Depends on bfd_pkg and box_filter_image_downscale from the hdl folder.
`default_nettype none
module box_filter_image_downscale_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_CYCLES = 100;

    // Copies of the block's parameters, used by the downscale predictor.
    localparam int  MAX_W    = bfd_pkg::MAX_WIDTH_DEF;
    localparam int  FRAC     = bfd_pkg::FRAC_BITS_DEF;
    localparam longint STEP_MIN = longint'(1) << FRAC;
    localparam longint STEP_MAX = longint'(bfd_pkg::MAX_RATIO_DEF) << FRAC;

    typedef struct {
        logic [bfd_pkg::PIX_W-1:0] r;
        logic [bfd_pkg::PIX_W-1:0] g;
        logic [bfd_pkg::PIX_W-1:0] b;
        logic                      last;
    } out_pixel_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [bfd_pkg::PIX_W-1:0]      red = '0;
    logic [bfd_pkg::PIX_W-1:0]      green = '0;
    logic [bfd_pkg::PIX_W-1:0]      blue = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [bfd_pkg::PIX_W-1:0]      out_red;
    logic [bfd_pkg::PIX_W-1:0]      out_green;
    logic [bfd_pkg::PIX_W-1:0]      out_blue;
    logic                           last_in_frame;

    box_filter_image_downscale i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last_in_frame(last_in_frame)
    );

    always #6 clk = ~clk;

    // Predictor state: configuration as written and the scan position.
    logic [bfd_pkg::SIZE_W-1:0] cfg_src_w = bfd_pkg::SIZE_RESET;
    logic [bfd_pkg::SIZE_W-1:0] cfg_src_h = bfd_pkg::SIZE_RESET;
    logic [bfd_pkg::SIZE_W-1:0] cfg_dst_w = bfd_pkg::SIZE_RESET;
    logic [bfd_pkg::SIZE_W-1:0] cfg_dst_h = bfd_pkg::SIZE_RESET;
    logic [bfd_pkg::STEP_W-1:0] cfg_x_step = bfd_pkg::STEP_RESET;
    logic [bfd_pkg::STEP_W-1:0] cfg_y_step = bfd_pkg::STEP_RESET;

    int unsigned col_red_sum [MAX_W];
    int unsigned col_green_sum [MAX_W];
    int unsigned col_blue_sum [MAX_W];
    int unsigned scan_col = 0;
    int unsigned scan_row = 0;
    int unsigned box_col = 0;
    int unsigned box_row = 0;
    longint      box_x0 = 0;
    longint      box_y0 = 0;

    out_pixel_t  expected_pixels[$];
    int          error_count = 0;
    int          pixels_sent = 0;
    int          burst_left = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo);
        if (v < lo)
            return lo;
        if (v > MAX_W)
            return MAX_W;
        return v;
    endfunction

    function automatic longint clamp_ratio(longint v);
        if (v < STEP_MIN)
            return STEP_MIN;
        if (v > STEP_MAX)
            return STEP_MAX;
        return v;
    endfunction

    // Advances the scan by one source pixel and queues the averaged output
    // word when this pixel closes a box.
    task automatic predict_downscale(logic [bfd_pkg::PIX_W-1:0] r,
                                     logic [bfd_pkg::PIX_W-1:0] g,
                                     logic [bfd_pkg::PIX_W-1:0] b);
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        longint      xs;
        longint      ys;
        longint      bw;
        longint      bh;
        int unsigned area;
        out_pixel_t  px;
        sw = clamp_dim(cfg_src_w, 1);
        sh = clamp_dim(cfg_src_h, 1);
        dw = clamp_dim(cfg_dst_w, 0);
        dh = clamp_dim(cfg_dst_h, 0);
        xs = clamp_ratio(cfg_x_step);
        ys = clamp_ratio(cfg_y_step);
        bw = xs >> FRAC;
        bh = ys >> FRAC;
        if (scan_col == 0)
        begin
            box_col = 0;
            box_x0 = 0;
            if (box_row < dh && scan_row >= box_y0 + bh)
            begin
                box_row++;
                box_y0 = (longint'(box_row) * ys) >> FRAC;
            end
        end
        if (box_col < dw && scan_col >= box_x0 + bw)
        begin
            box_col++;
            box_x0 = (longint'(box_col) * xs) >> FRAC;
        end
        if (box_row < dh && box_col < dw && scan_row >= box_y0 && scan_row < box_y0 + bh
            && scan_col >= box_x0 && scan_col < box_x0 + bw)
        begin
            if (scan_row == box_y0 && scan_col == box_x0)
            begin
                col_red_sum[box_col] = r;
                col_green_sum[box_col] = g;
                col_blue_sum[box_col] = b;
            end
            else
            begin
                col_red_sum[box_col] += r;
                col_green_sum[box_col] += g;
                col_blue_sum[box_col] += b;
            end
            if (scan_row == box_y0 + bh - 1 && scan_col == box_x0 + bw - 1)
            begin
                area = int'(bw * bh);
                px.r = bfd_pkg::PIX_W'(col_red_sum[box_col] / area);
                px.g = bfd_pkg::PIX_W'(col_green_sum[box_col] / area);
                px.b = bfd_pkg::PIX_W'(col_blue_sum[box_col] / area);
                px.last = (box_col == dw - 1) && (box_row == dh - 1);
                expected_pixels.push_back(px);
            end
        end
        scan_col++;
        if (scan_col >= sw)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= sh)
            begin
                scan_row = 0;
                box_row = 0;
                box_y0 = 0;
            end
        end
    endtask

    // Writes all six registers, one per clock, and mirrors them in the predictor.
    task automatic configure(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, int unsigned xs, int unsigned ys);
        logic [bfd_pkg::CFG_DATA_W-1:0] vals[6];
        logic [bfd_pkg::CFG_IDX_W-1:0]  idx[6];
        vals = '{bfd_pkg::CFG_DATA_W'(sw), bfd_pkg::CFG_DATA_W'(sh),
                 bfd_pkg::CFG_DATA_W'(dw), bfd_pkg::CFG_DATA_W'(dh),
                 bfd_pkg::CFG_DATA_W'(xs), bfd_pkg::CFG_DATA_W'(ys)};
        idx = '{bfd_pkg::REG_SRC_WIDTH, bfd_pkg::REG_SRC_HEIGHT, bfd_pkg::REG_DST_WIDTH,
                bfd_pkg::REG_DST_HEIGHT, bfd_pkg::REG_X_STEP, bfd_pkg::REG_Y_STEP};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_src_w = bfd_pkg::SIZE_W'(sw);
        cfg_src_h = bfd_pkg::SIZE_W'(sh);
        cfg_dst_w = bfd_pkg::SIZE_W'(dw);
        cfg_dst_h = bfd_pkg::SIZE_W'(dh);
        cfg_x_step = bfd_pkg::STEP_W'(xs);
        cfg_y_step = bfd_pkg::STEP_W'(ys);
    endtask

    // Sends one source pixel. Words go out in bursts; between bursts the valid
    // line may drop for a random gap.
    task automatic send_pixel(logic [bfd_pkg::PIX_W-1:0] r, logic [bfd_pkg::PIX_W-1:0] g,
                              logic [bfd_pkg::PIX_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_downscale(r, g, b);
        pixels_sent++;
        burst_left--;
    endtask

    task automatic send_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(bfd_pkg::PIX_W'($urandom), bfd_pkg::PIX_W'($urandom),
                       bfd_pkg::PIX_W'($urandom));
    endtask

    task automatic send_frames(int frames);
        int count;
        count = frames * clamp_dim(cfg_src_w, 1) * clamp_dim(cfg_src_h, 1);
        send_pixels(count);
    endtask

    // Waits for the last expected word, then lets a pixel that closes no box
    // finish its work before the registers change.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel(8'hAA, 8'h55, 8'h0F);
        wait_idle();
    endtask

    // Two 2x2 boxes from a 4x2 frame, red and green values at the channel extremes.
    task automatic test_two_by_two_boxes();
        configure(4, 2, 2, 1, 2 << 16, 2 << 16);
        for (int i = 0; i < 8; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'h01);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // Steps of zero are taken as 1.0; a zero source width as one pixel.
        configure(0, 2, 1, 2, 0, 0);
        send_frames(1);
        wait_idle();
        // No output columns: nothing may come out.
        configure(2, 2, 0, 1, 1 << 16, 1 << 16);
        send_frames(1);
        wait_idle();
        // The second box runs past the right edge and never closes.
        configure(3, 1, 2, 1, 2 << 16, 1 << 16);
        send_frames(1);
        wait_idle();
        // Steps beyond the largest ratio are clamped, so the box is too wide.
        configure(2, 1, 1, 1, 23'h7FFFFF, 1 << 16);
        send_frames(1);
        wait_idle();
    endtask

    // The first boxes of one wide row at the ratio limit, with oversized sizes clamped.
    task automatic test_widest_row();
        configure(2047, 1, 2047, 1, 4194304, 1 << 16);
        send_pixels(256);
        wait_idle();
    endtask

    // Random small frames; fractional steps make boxes start at uneven places.
    task automatic test_random_frames();
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned xmax;
        int unsigned ymax;
        while (pixels_sent < 300)
        begin
            sw = $urandom_range(1, 16);
            sh = $urandom_range(1, 8);
            dw = $urandom_range(1, sw + 1);
            dh = $urandom_range(1, sh);
            xmax = (sw << 16) / dw;
            ymax = (sh << 16) / dh;
            if (xmax < (1 << 16))
                xmax = 1 << 16;
            if (ymax < (1 << 16))
                ymax = 1 << 16;
            configure(sw, sh, dw, dh, $urandom_range(1 << 16, xmax),
                      $urandom_range(1 << 16, ymax));
            send_frames($urandom_range(1, 3));
            wait_idle();
        end
    endtask

    // The receiver stalls in stretches: sometimes never, sometimes often.
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compares each accepted output word with the oldest expected one.
    always @(posedge clk)
    begin
        out_pixel_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word r=%0h g=%0h b=%0h last=%0b", $time,
                         out_red, out_green, out_blue, last_in_frame);
                error_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (out_red !== exp_px.r || out_green !== exp_px.g ||
                    out_blue !== exp_px.b || last_in_frame !== exp_px.last)
                begin
                    $display({"%0t: expected r=%0h g=%0h b=%0h last=%0b,",
                              " got r=%0h g=%0h b=%0h last=%0b"},
                             $time, exp_px.r, exp_px.g, exp_px.b, exp_px.last,
                             out_red, out_green, out_blue, last_in_frame);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_two_by_two_boxes();
        test_special_cases();
        test_random_frames();
        test_widest_row();
        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_pixels.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Limit: the slowest pixel waits for the divider, plus stalls and gaps.
    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
